>>> rtl/i2cbl_pkg.sv
// Types and constants for the bit-level I2C master sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package i2cbl_pkg;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4,
        ACT_CHECK = 3'd5,
        ACT_ACK   = 3'd6,
        ACT_NACK  = 3'd7
    } action_t;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned QDEPTH   = 2;
    localparam int unsigned QPTR_W   = 1;
    localparam int unsigned QCNT_W   = 2;

    localparam logic [IDX_W-1:0] WRITE_LAST = IDX_W'(23);
    localparam logic [IDX_W-1:0] READ_LAST  = IDX_W'(15);
    localparam logic [IDX_W-1:0] SHORT_LAST = IDX_W'(2);

    typedef logic [1:0] phase_t;
    localparam phase_t PH_FIRST  = 2'd0;
    localparam phase_t PH_SECOND = 2'd1;
    localparam phase_t PH_THIRD  = 2'd2;

    typedef struct packed {
        logic              is_cmd;
        action_t           action;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } qitem_t;

endpackage

`default_nettype wire

>>> rtl/i2cbl_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on i2cbl_pkg.
`default_nettype none

interface i2cbl_req_if;
    import i2cbl_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;

    modport source (output valid, action, write_data, sda_in, input ready);
    modport sink   (input valid, action, write_data, sda_in, output ready);
endinterface

interface i2cbl_res_if;
    import i2cbl_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_seen;
    logic              rejected;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_seen, rejected, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_seen, rejected, output ready);
endinterface

`default_nettype wire

>>> rtl/i2cbl_front.sv
// Front end: accepts requests and classifies them as tick or command.
// Depends on i2cbl_pkg and i2cbl_if.
`default_nettype none

module i2cbl_front (
    i2cbl_req_if.sink           items,
    input  wire logic           q_full,
    output i2cbl_pkg::qitem_t   push_item,
    output logic                push
);
    import i2cbl_pkg::*;

    action_t act;

    assign act   = action_t'(items.action);
    assign items.ready = !q_full;
    assign push  = items.valid && !q_full;

    always_comb
    begin
        push_item.is_cmd     = (act != ACT_TICK);
        push_item.action     = act;
        push_item.write_data = (act == ACT_WRITE) ? items.write_data : '0;
        push_item.sda_in     = (act == ACT_TICK) ? items.sda_in : 1'b0;
    end
endmodule

`default_nettype wire

>>> rtl/i2cbl_queue.sv
// Two-entry queue between the front end and the bit sequencer.
// Depends on i2cbl_pkg.
`default_nettype none

module i2cbl_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire i2cbl_pkg::qitem_t  push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output i2cbl_pkg::qitem_t       head
);
    import i2cbl_pkg::*;

    qitem_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

`default_nettype wire

>>> rtl/i2cbl_seq.sv
// Back end: runs the period programs of each command and registers results.
// Depends on i2cbl_pkg and i2cbl_if.
`default_nettype none

module i2cbl_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire i2cbl_pkg::qitem_t  q_head,
    output logic                    pop,
    i2cbl_res_if.source             results
);
    import i2cbl_pkg::*;

    action_t             cmd_reg,   cmd_next;
    logic [IDX_W-1:0]    idx_reg,   idx_next;
    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [BYTE_W-1:0]   rx_reg,    rx_next;
    logic                ack_reg,   ack_next;
    logic                scl_reg,   scl_next;
    logic                sda_reg,   sda_next;
    logic                dir_reg,   dir_next;
    logic                done_next;
    logic                rej_next;
    logic                enter;
    logic                last;
    logic                out_valid_reg;
    logic                busy_out_reg;
    logic                done_out_reg;
    logic                rej_out_reg;

    assign pop = q_valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        dir_next   = dir_reg;
        done_next  = 1'b0;
        rej_next   = 1'b0;
        enter      = 1'b0;
        last       = 1'b0;

        if (q_head.is_cmd)
        begin
            if (cmd_reg != ACT_TICK)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                cmd_next   = q_head.action;
                idx_next   = '0;
                phase_next = PH_FIRST;
                if (q_head.action == ACT_WRITE)
                begin
                    shift_next = q_head.write_data;
                end
                enter = 1'b1;
            end
        end
        else if (cmd_reg != ACT_TICK)
        begin
            if (cmd_reg == ACT_READ && !idx_reg[0])
            begin
                shift_next = {shift_reg[BYTE_W-2:0], q_head.sda_in};
            end
            if (cmd_reg == ACT_CHECK && phase_reg == PH_SECOND)
            begin
                ack_next = !q_head.sda_in;
            end
            if (cmd_reg == ACT_WRITE && phase_reg == PH_THIRD)
            begin
                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
            end

            case (cmd_reg)
                ACT_WRITE: last = (idx_reg == WRITE_LAST);
                ACT_READ:  last = (idx_reg == READ_LAST);
                default:   last = (idx_reg == SHORT_LAST);
            endcase

            if (last)
            begin
                if (cmd_reg == ACT_WRITE || cmd_reg == ACT_ACK)
                begin
                    sda_next = 1'b1;
                end
                if (cmd_reg == ACT_READ)
                begin
                    rx_next  = shift_next;
                    dir_next = 1'b1;
                end
                if (cmd_reg == ACT_CHECK)
                begin
                    dir_next = 1'b1;
                end
                cmd_next   = ACT_TICK;
                idx_next   = '0;
                phase_next = PH_FIRST;
                done_next  = 1'b1;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                phase_next = (phase_reg == PH_THIRD) ? PH_FIRST : phase_reg + 1'b1;
                enter      = 1'b1;
            end
        end

        if (enter)
        begin
            case (cmd_next)
                ACT_START:
                begin
                    case (phase_next)
                        PH_FIRST:
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            dir_next = 1'b1;
                        end
                        PH_SECOND: sda_next = 1'b0;
                        default:   scl_next = 1'b0;
                    endcase
                end
                ACT_STOP:
                begin
                    case (phase_next)
                        PH_FIRST:
                        begin
                            dir_next = 1'b1;
                            scl_next = 1'b0;
                            sda_next = 1'b0;
                        end
                        PH_SECOND: scl_next = 1'b1;
                        default:   sda_next = 1'b1;
                    endcase
                end
                ACT_WRITE:
                begin
                    case (phase_next)
                        PH_FIRST:
                        begin
                            dir_next = 1'b1;
                            sda_next = shift_next[BYTE_W-1];
                        end
                        PH_SECOND: scl_next = 1'b1;
                        default:   scl_next = 1'b0;
                    endcase
                end
                ACT_READ:
                begin
                    if (!idx_next[0])
                    begin
                        dir_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                ACT_CHECK:
                begin
                    case (phase_next)
                        PH_FIRST:  dir_next = 1'b0;
                        PH_SECOND: scl_next = 1'b1;
                        default:   scl_next = 1'b0;
                    endcase
                end
                ACT_ACK, ACT_NACK:
                begin
                    case (phase_next)
                        PH_FIRST:
                        begin
                            dir_next = 1'b1;
                            sda_next = (cmd_next == ACT_NACK);
                        end
                        PH_SECOND: scl_next = 1'b1;
                        default:   scl_next = 1'b0;
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= ACT_TICK;
            idx_reg       <= '0;
            phase_reg     <= PH_FIRST;
            shift_reg     <= '0;
            rx_reg        <= '0;
            ack_reg       <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            dir_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            busy_out_reg  <= 1'b0;
            done_out_reg  <= 1'b0;
            rej_out_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cmd_reg       <= cmd_next;
                idx_reg       <= idx_next;
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                rx_reg        <= rx_next;
                ack_reg       <= ack_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                dir_reg       <= dir_next;
                busy_out_reg  <= (cmd_next != ACT_TICK);
                done_out_reg  <= done_next;
                rej_out_reg   <= rej_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.scl_level = scl_reg;
    assign results.sda_level = sda_reg;
    assign results.sda_drive = dir_reg;
    assign results.busy_res  = busy_out_reg;
    assign results.done_res  = done_out_reg;
    assign results.read_data = rx_reg;
    assign results.ack_seen  = ack_reg;
    assign results.rejected  = rej_out_reg;
endmodule

`default_nettype wire

>>> rtl/i2c_bit_level_master.sv
// Bit-level I2C master sequencer. Each request is a command (start, stop, write
// byte, read byte, check ack, send ack, send nack) or a tick that ends one bus
// period and carries the sampled SDA level; every request yields exactly one
// result with the SCL/SDA levels and SDA direction for the coming period, status
// flags, the last read byte and the last ack check. A command while busy is
// rejected. One request is accepted per cycle while the queue is not full; it is
// written into the two-entry request queue, and the sequencer takes it from the
// queue and registers its result at the same edge, once the result register is
// empty or its result is being taken. A result held by the receiver freezes the
// sequencer; the queue then fills and input stalls. Throughput is set by the single
// sequencer state update, one request per cycle while the receiver takes results.
// Depends on i2cbl_pkg, i2cbl_if, i2cbl_front, i2cbl_queue and i2cbl_seq.
`default_nettype none

module i2c_bit_level_master (
    input  wire logic   clk,
    input  wire logic   rst_n,
    i2cbl_req_if.sink   items,
    i2cbl_res_if.source results
);
    import i2cbl_pkg::*;

    qitem_t push_item;
    qitem_t head;
    logic   push;
    logic   full;
    logic   pop;
    logic   not_empty;

    i2cbl_front u_front (
        .items     (items),
        .q_full    (full),
        .push_item (push_item),
        .push      (push)
    );

    i2cbl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    i2cbl_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_head  (head),
        .pop     (pop),
        .results (results)
    );
endmodule

`default_nettype wire

>>> sim/i2c_bit_level_master_tb.sv
// Testbench for i2c_bit_level_master: drives command and tick requests, predicts
// every result with its own sequencer model and checks each result in order.
// Depends on i2cbl_pkg, i2cbl_if and the i2c_bit_level_master RTL.
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;
    import i2cbl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_seen;
        logic              rejected;
    } bus_result_t;

    logic clk;
    logic rst_n;

    i2cbl_req_if req_ch ();
    i2cbl_res_if res_ch ();

    i2c_bit_level_master u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (req_ch),
        .results (res_ch)
    );

    bus_result_t expected_bus_q[$];
    int          errors;
    int          cycle_count;
    int          sequenced_items;
    bit          src_gaps;
    bit          sink_gaps;
    int          hold_request;
    int          rx_stall;

    action_t           seq_cmd;
    logic [IDX_W-1:0]  seq_idx;
    logic [BYTE_W-1:0] shift_q;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_q;
    logic              scl_q;
    logic              sda_q;
    logic              dir_q;

    always #2 clk = ~clk;

    function automatic logic [IDX_W-1:0] last_period(action_t c);
        case (c)
            ACT_WRITE: return WRITE_LAST;
            ACT_READ:  return READ_LAST;
            default:   return SHORT_LAST;
        endcase
    endfunction

    function void enter_bus_period();
        case (seq_cmd)
            ACT_START:
                if (seq_idx == 0)
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    dir_q = 1'b1;
                end
                else if (seq_idx == 1) sda_q = 1'b0;
                else scl_q = 1'b0;
            ACT_STOP:
                if (seq_idx == 0)
                begin
                    dir_q = 1'b1;
                    scl_q = 1'b0;
                    sda_q = 1'b0;
                end
                else if (seq_idx == 1) scl_q = 1'b1;
                else sda_q = 1'b1;
            ACT_WRITE:
                if (seq_idx % 3 == 0)
                begin
                    dir_q = 1'b1;
                    sda_q = shift_q[BYTE_W-1];
                end
                else if (seq_idx % 3 == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            ACT_READ:
                if (!seq_idx[0])
                begin
                    dir_q = 1'b0;
                    scl_q = 1'b1;
                end
                else scl_q = 1'b0;
            ACT_CHECK:
                if (seq_idx == 0) dir_q = 1'b0;
                else if (seq_idx == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            ACT_ACK, ACT_NACK:
                if (seq_idx == 0)
                begin
                    dir_q = 1'b1;
                    sda_q = (seq_cmd == ACT_NACK);
                end
                else if (seq_idx == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            default: ;
        endcase
    endfunction

    function void predict_bus_step(action_t a, logic [BYTE_W-1:0] wd, logic s);
        bus_result_t r;
        logic        fin;
        logic        rej;
        logic        was_idle;
        fin = 1'b0;
        rej = 1'b0;
        was_idle = (seq_cmd == ACT_TICK);
        if (a != ACT_TICK)
        begin
            if (!was_idle) rej = 1'b1;
            else
            begin
                seq_cmd = a;
                seq_idx = '0;
                if (a == ACT_WRITE) shift_q = wd;
                enter_bus_period();
            end
        end
        else if (!was_idle)
        begin
            if (seq_cmd == ACT_READ && !seq_idx[0]) shift_q = {shift_q[BYTE_W-2:0], s};
            if (seq_cmd == ACT_CHECK && seq_idx == 1) ack_q = ~s;
            if (seq_cmd == ACT_WRITE && seq_idx % 3 == 2) shift_q = shift_q << 1;
            if (seq_idx == last_period(seq_cmd))
            begin
                if (seq_cmd == ACT_WRITE || seq_cmd == ACT_ACK) sda_q = 1'b1;
                if (seq_cmd == ACT_READ)
                begin
                    rx_byte = shift_q;
                    dir_q = 1'b1;
                end
                if (seq_cmd == ACT_CHECK) dir_q = 1'b1;
                seq_cmd = ACT_TICK;
                seq_idx = '0;
                fin = 1'b1;
            end
            else
            begin
                seq_idx = seq_idx + 1'b1;
                enter_bus_period();
            end
        end
        if (!rej && !(a == ACT_TICK && was_idle)) sequenced_items++;
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = dir_q;
        r.busy_res  = (seq_cmd != ACT_TICK);
        r.done_res  = fin;
        r.read_data = rx_byte;
        r.ack_seen  = ack_q;
        r.rejected  = rej;
        expected_bus_q.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            predict_bus_step(action_t'(req_ch.action), req_ch.write_data, req_ch.sda_in);
    end

    task check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                     input logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        bus_result_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_bus_q.size() == 0)
            begin
                $display("%0t: result with no request pending", $time);
                errors++;
            end
            else
            begin
                e = expected_bus_q.pop_front();
                check_field("scl_level", BYTE_W'(e.scl_level), BYTE_W'(res_ch.scl_level));
                check_field("sda_level", BYTE_W'(e.sda_level), BYTE_W'(res_ch.sda_level));
                check_field("sda_drive", BYTE_W'(e.sda_drive), BYTE_W'(res_ch.sda_drive));
                check_field("busy_res", BYTE_W'(e.busy_res), BYTE_W'(res_ch.busy_res));
                check_field("done_res", BYTE_W'(e.done_res), BYTE_W'(res_ch.done_res));
                check_field("read_data", e.read_data, res_ch.read_data);
                check_field("ack_seen", BYTE_W'(e.ack_seen), BYTE_W'(res_ch.ack_seen));
                check_field("rejected", BYTE_W'(e.rejected), BYTE_W'(res_ch.rejected));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                rx_stall = hold_request;
                hold_request = 0;
            end
            if (rx_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                rx_stall--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                rx_stall = $urandom_range(0, 18);
            end
            else res_ch.ready <= 1'b1;
        end
    end

    task send_item(input action_t a, input logic [BYTE_W-1:0] wd, input logic s);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= a;
        req_ch.write_data <= wd;
        req_ch.sda_in     <= s;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task run_command(input action_t c, input logic [BYTE_W-1:0] wd,
                     input logic [23:0] sda_bits, input bit noisy);
        send_item(c, wd, 1'($urandom_range(0, 1)));
        for (int k = 0; k <= last_period(c); k++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(action_t'($urandom_range(0, 7)), BYTE_W'($urandom),
                          1'($urandom_range(0, 1)));
            send_item(ACT_TICK, BYTE_W'($urandom), sda_bits[k]);
        end
    endtask

    task wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_bus_q.size() != 0) @(posedge clk);
    endtask

    task test_idle_ticks();
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_TICK, 8'hFF, 1'b1);
    endtask

    task test_bus_framing();
        send_item(ACT_START, 8'h00, 1'b1);
        send_item(ACT_WRITE, 8'hFF, 1'b0);
        send_item(ACT_NACK, 8'h00, 1'b1);
        repeat (3) send_item(ACT_TICK, 8'h00, 1'b1);
        run_command(ACT_STOP, 8'hFF, 24'hFFFFFF, 1'b0);
    endtask

    task test_ack_cycles();
        run_command(ACT_CHECK, 8'h00, 24'h000005, 1'b0);
        run_command(ACT_CHECK, 8'h00, 24'h000002, 1'b0);
        run_command(ACT_ACK, 8'h00, 24'h000000, 1'b0);
        run_command(ACT_NACK, 8'h00, 24'h000007, 1'b0);
    endtask

    task test_byte_transfers();
        run_command(ACT_WRITE, 8'hFF, 24'($urandom), 1'b0);
        run_command(ACT_READ, 8'hFF, 24'h000000, 1'b0);
    endtask

    task test_random_traffic(input int target);
        while (sequenced_items < target)
            run_command(action_t'($urandom_range(1, 7)), BYTE_W'($urandom),
                        24'($urandom), 1'b1);
    endtask

    task test_receiver_backpressure();
        hold_request = 80;
        run_command(ACT_WRITE, BYTE_W'($urandom), 24'($urandom), 1'b0);
        wait_all_results();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_TICK;
        req_ch.write_data = '0;
        req_ch.sda_in = 1'b0;
        errors = 0;
        cycle_count = 0;
        sequenced_items = 0;
        hold_request = 0;
        rx_stall = 0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        seq_cmd = ACT_TICK;
        seq_idx = '0;
        shift_q = '0;
        rx_byte = '0;
        ack_q = 1'b0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        dir_q = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_bus_framing();
        test_ack_cycles();
        test_byte_transfers();
        test_random_traffic(380);
        test_receiver_backpressure();
        test_random_traffic(600);
        wait_all_results();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        test_random_traffic(720);

        wait_all_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/i2cbl_pkg.sv
rtl/i2cbl_if.sv
rtl/i2cbl_front.sv
rtl/i2cbl_queue.sv
rtl/i2cbl_seq.sv
rtl/i2c_bit_level_master.sv
sim/i2c_bit_level_master_tb.sv
